// ===== hdl/universal_source_finder_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the universal source finder unit
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef UNIVERSAL_SOURCE_FINDER_UNIT_ASSERT_SVH
`define UNIVERSAL_SOURCE_FINDER_UNIT_ASSERT_SVH

// same-cycle implication
`define USF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define USF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/usf_pkg.sv =====
// ----------------------------------------------------------------------------
// usf_pkg
// Shared constants and controller/datapath interface types.
// ----------------------------------------------------------------------------
package usf_pkg;

    localparam int MAX_NODES = 16;
    localparam int NODE_W    = $clog2(MAX_NODES);
    localparam int CNT_W     = NODE_W + 1;
    localparam int POS_W     = 2 * NODE_W + 1;
    localparam int ADDR_W    = 2 * NODE_W;
    localparam int WEIGHT_W  = 16;

    localparam logic [CNT_W-1:0] NODE_COUNT_RESET = CNT_W'(7);

    typedef struct packed {
        logic load;
        logic recalc_step;
        logic elim_update;
        logic verify_start;
        logic verify_step;
        logic result_load;
    } usf_cmd_t;

    typedef struct packed {
        logic recalc_done;
        logic elim_done;
        logic verify_done;
        logic out_free;
    } usf_sts_t;

endpackage

// ===== hdl/usf_datapath.sv =====
// ----------------------------------------------------------------------------
// usf_datapath
// Link matrix store, load position tracking, candidate elimination and
// verification registers, and the result register.
// ----------------------------------------------------------------------------
`include "universal_source_finder_unit_assert.svh"

module usf_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [usf_pkg::CNT_W-1:0]    cfg_wdata,
    input  logic [usf_pkg::WEIGHT_W-1:0] link_weight,
    input  logic                         last_entry,
    input  usf_pkg::usf_cmd_t            cmd,
    output usf_pkg::usf_sts_t            sts,
    input  logic                         out_ready,
    output logic                         out_valid,
    output logic                         server_found,
    output logic [usf_pkg::CNT_W-1:0]    server_number
);
    import usf_pkg::*;

    logic [CNT_W-1:0]    node_count_reg;
    logic [CNT_W-1:0]    n_eff;
    logic [CNT_W-1:0]    n_last;
    logic [POS_W-1:0]    total;

    logic [POS_W-1:0]    pos_reg;
    logic [CNT_W-1:0]    row_reg;
    logic [POS_W-1:0]    col_reg;
    logic                in_range;
    logic                col_wrap;
    logic                recalc_done;
    logic [ADDR_W-1:0]   wr_addr;

    logic                link_mem [1 << ADDR_W];
    logic [ADDR_W-1:0]   rd_addr_a;
    logic [ADDR_W-1:0]   rd_addr_b;
    logic                rd_a_reg;
    logic                rd_b_reg;

    logic [NODE_W-1:0]   cand_reg;
    logic [CNT_W-1:0]    idx_reg;
    logic                idx_lt_n;
    logic                ok_reg;
    logic                pend_reg;
    logic [NODE_W-1:0]   pend_idx_reg;
    logic                fail;

    logic                out_valid_reg;
    logic                found_reg;
    logic [CNT_W-1:0]    number_reg;

    always_comb
    begin
        if (node_count_reg == '0)
            n_eff = CNT_W'(1);
        else if (node_count_reg > CNT_W'(MAX_NODES))
            n_eff = CNT_W'(MAX_NODES);
        else
            n_eff = node_count_reg;
    end

    assign n_last      = n_eff - CNT_W'(1);
    assign total       = POS_W'(n_eff) * POS_W'(n_eff);
    assign in_range    = pos_reg < total;
    assign col_wrap    = col_reg == POS_W'(n_last);
    assign recalc_done = (col_reg < POS_W'(n_eff)) || (row_reg == n_eff);
    assign wr_addr     = {row_reg[NODE_W-1:0], col_reg[NODE_W-1:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            node_count_reg <= NODE_COUNT_RESET;
        else if (cfg_we)
            node_count_reg <= cfg_wdata;
    end

    // row and column follow the position under the current node count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            row_reg <= '0;
            col_reg <= '0;
        end
        else if (cfg_we)
        begin
            row_reg <= '0;
            col_reg <= pos_reg;
        end
        else if (cmd.load)
        begin
            if (last_entry)
            begin
                pos_reg <= '0;
                row_reg <= '0;
                col_reg <= '0;
            end
            else if (in_range)
            begin
                pos_reg <= pos_reg + POS_W'(1);
                if (col_wrap)
                begin
                    col_reg <= '0;
                    row_reg <= row_reg + CNT_W'(1);
                end
                else
                begin
                    col_reg <= col_reg + POS_W'(1);
                end
            end
        end
        else if (cmd.recalc_step && !recalc_done)
        begin
            col_reg <= col_reg - POS_W'(n_eff);
            row_reg <= row_reg + CNT_W'(1);
        end
    end

    assign rd_addr_a = {cand_reg, idx_reg[NODE_W-1:0]};
    assign rd_addr_b = {idx_reg[NODE_W-1:0], cand_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.load && in_range)
            link_mem[wr_addr] <= |link_weight;
        rd_a_reg <= link_mem[rd_addr_a];
        rd_b_reg <= link_mem[rd_addr_b];
    end

    assign idx_lt_n = idx_reg < n_eff;
    assign fail     = pend_reg && (((pend_idx_reg != cand_reg) && !rd_a_reg) || rd_b_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cand_reg     <= '0;
            idx_reg      <= '0;
            ok_reg       <= 1'b0;
            pend_reg     <= 1'b0;
            pend_idx_reg <= '0;
        end
        else if (cmd.load && last_entry)
        begin
            cand_reg <= '0;
            idx_reg  <= CNT_W'(1);
        end
        else if (cmd.elim_update)
        begin
            if (!rd_a_reg)
                cand_reg <= idx_reg[NODE_W-1:0];
            idx_reg <= idx_reg + CNT_W'(1);
        end
        else if (cmd.verify_start)
        begin
            idx_reg  <= '0;
            ok_reg   <= 1'b1;
            pend_reg <= 1'b0;
        end
        else if (cmd.verify_step)
        begin
            pend_reg     <= idx_lt_n;
            pend_idx_reg <= idx_reg[NODE_W-1:0];
            if (idx_lt_n)
                idx_reg <= idx_reg + CNT_W'(1);
            if (fail)
                ok_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.result_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.result_load)
        begin
            found_reg  <= ok_reg;
            number_reg <= ok_reg ? ({1'b0, cand_reg} + CNT_W'(1)) : '0;
        end
    end

    assign sts.recalc_done = recalc_done;
    assign sts.elim_done   = !idx_lt_n;
    assign sts.verify_done = !idx_lt_n && !pend_reg;
    assign sts.out_free    = !out_valid_reg || out_ready;

    assign out_valid     = out_valid_reg;
    assign server_found  = found_reg;
    assign server_number = number_reg;

    `USF_ASSERT_IMP(a_found_has_number, out_valid_reg,
        found_reg == (number_reg != '0), "found flag and node number disagree")
    `USF_ASSERT_IMP(a_write_inside_matrix, cmd.load && in_range,
        (row_reg < n_eff) && (col_reg < POS_W'(n_eff)),
        "entry written outside the active matrix")

endmodule

// ===== hdl/usf_ctrl.sv =====
// ----------------------------------------------------------------------------
// usf_ctrl
// Sequencer: loading, position recalculation after a node count write,
// pairwise elimination, verification and result handoff.
// ----------------------------------------------------------------------------
`include "universal_source_finder_unit_assert.svh"

module usf_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    input  logic              last_entry,
    input  logic              cfg_we,
    input  usf_pkg::usf_sts_t sts,
    output usf_pkg::usf_cmd_t cmd,
    output logic              s_tready
);
    import usf_pkg::*;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_RECALC,
        ST_ELIM_RD,
        ST_ELIM_EV,
        ST_VERIFY,
        ST_RESULT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   ready_reg;
    logic   accept;

    assign accept = s_tvalid && ready_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (accept && last_entry)
                    state_next = ST_ELIM_RD;
                else if (cfg_we)
                    state_next = ST_RECALC;
            end
            ST_RECALC:
            begin
                if (!cfg_we && sts.recalc_done)
                    state_next = ST_LOAD;
            end
            ST_ELIM_RD:
            begin
                state_next = sts.elim_done ? ST_VERIFY : ST_ELIM_EV;
            end
            ST_ELIM_EV:
            begin
                state_next = ST_ELIM_RD;
            end
            ST_VERIFY:
            begin
                if (sts.verify_done)
                    state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (sts.out_free)
                    state_next = ST_LOAD;
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            ready_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= state_next == ST_LOAD;
        end
    end

    assign cmd.load         = accept;
    assign cmd.recalc_step  = state_reg == ST_RECALC;
    assign cmd.elim_update  = state_reg == ST_ELIM_EV;
    assign cmd.verify_start = (state_reg == ST_ELIM_RD) && sts.elim_done;
    assign cmd.verify_step  = state_reg == ST_VERIFY;
    assign cmd.result_load  = (state_reg == ST_RESULT) && sts.out_free;

    assign s_tready = ready_reg;

    `USF_ASSERT_IMP(a_ready_only_loading, ready_reg, state_reg == ST_LOAD,
        "input ready outside loading")
    `USF_ASSERT_NXT(a_last_starts_search, accept && last_entry,
        state_reg == ST_ELIM_RD, "last entry did not start the search")
    `USF_ASSERT_IMP(a_result_slot_free, cmd.result_load, sts.out_free,
        "result loaded over an untaken result")

endmodule

// ===== hdl/universal_source_finder_unit.sv =====
// ----------------------------------------------------------------------------
// universal_source_finder_unit
// Loads an n by n link matrix and finds the node that links to every other
// node and receives no link.
//
//   channel   dir  handshake                    payload
//   s_axis    in   s_axis_tvalid/s_axis_tready  tdata: link_weight, tlast: last_entry
//   m_axis    out  m_axis_tvalid/m_axis_tready  tdata: server_number, tuser: server_found
//   cfg       in   cfg_we                       cfg_wdata: node_count
//
// Entries load at one per cycle while tready is high. After the last entry
// tready stays low for the search: each elimination step has a read state
// and an evaluate state on the registered matrix read, then each node is
// verified in turn. A node_count write stalls input while the load row and
// column are rederived. The matrix store is not cleared at reset; it is
// valid once loaded. A waiting result does not block loading of the next matrix.
// ----------------------------------------------------------------------------
module universal_source_finder_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [usf_pkg::CNT_W-1:0]    cfg_wdata,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [usf_pkg::WEIGHT_W-1:0] s_axis_tdata,   // [15:0] link_weight
    input  logic                         s_axis_tlast,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [7:0]                   m_axis_tdata,   // [4:0] server_number
    output logic [0:0]                   m_axis_tuser    // [0] server_found
);
    import usf_pkg::*;

    usf_cmd_t         cmd;
    usf_sts_t         sts;
    logic             found;
    logic [CNT_W-1:0] number;

    usf_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_axis_tvalid),
        .last_entry (s_axis_tlast),
        .cfg_we     (cfg_we),
        .sts        (sts),
        .cmd        (cmd),
        .s_tready   (s_axis_tready)
    );

    usf_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .link_weight   (s_axis_tdata),
        .last_entry    (s_axis_tlast),
        .cmd           (cmd),
        .sts           (sts),
        .out_ready     (m_axis_tready),
        .out_valid     (m_axis_tvalid),
        .server_found  (found),
        .server_number (number)
    );

    assign m_axis_tdata = {(8 - CNT_W)'(0), number};
    assign m_axis_tuser = found;

endmodule
